@@ src/llm_pkg.sv @@
`default_nettype none

package llm_pkg;

   // node store depth unless the top level is told otherwise
   localparam int unsigned CAPACITY_DEFAULT = 32;

   // width of a stored value word
   localparam int unsigned DATA_W = 32;

   // request command codes
   typedef enum logic [1:0] {
      CMD_PUSH_FRONT = 2'd0,
      CMD_PUSH_REAR  = 2'd1,
      CMD_DELETE     = 2'd2,
      CMD_DUMP       = 2'd3
   } cmd_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_DONE = 2'd0,
      ST_FULL = 2'd1,
      ST_NONE = 2'd2,
      ST_ITEM = 2'd3
   } status_type;

endpackage

`default_nettype wire

@@ src/linked_list_manager_top.sv @@
// Linked list manager: a bounded singly linked list of signed 32-bit values
// held in a node store of CAPACITY entries with a free list.
// Input channel (req_): one word carries a command and a value. Commands are
// push front, push rear, delete first match and dump. The result channel
// (rsp_) returns status, item value and a last flag; every command ends with
// exactly one word that has rsp_last set.
// Timing: req_ready is high only while the sequencer is idle. A push passes
// through S_PUSH and S_RESP before its word enters the result register.
// Delete walks the list one node per cycle. Dump issues one word per cycle
// while the result register is free. Each step is bound by the single read
// port of the node memories (registered read data).
// The result register lets a finished word wait while the next command is
// accepted; while a word waits and rsp_ready is low the sequencer holds its
// place before issuing another word and resumes when the word is taken.
// Reset (synchronous, active high) empties the list; the free chain starts
// in index order with no clearing pass, so the block is ready the cycle
// after reset.
`default_nettype none

module linked_list_manager_top import llm_pkg::*; #(
   parameter int unsigned CAPACITY = CAPACITY_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_command,
   input  wire logic signed [31:0] req_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [1:0]              rsp_status,
   output logic signed [31:0]      rsp_item_value,
   output logic                    rsp_last
);

   localparam int unsigned IDX_W = $clog2(CAPACITY);
   localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_PUSH,
      S_SEARCH,
      S_FREE,
      S_DUMP,
      S_RESP
   } state_type;

   state_type         state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [DATA_W-1:0] value_ff, value_in;
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [IDX_W-1:0]  tail_ff, tail_in;
   logic [IDX_W-1:0]  free_ff, free_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  cur_ff, cur_in;
   logic [IDX_W-1:0]  prev_ff, prev_in;
   logic [CNT_W-1:0]  step_ff, step_in;
   status_type        pend_ff, pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic              val_we;
   logic [IDX_W-1:0]  val_waddr;
   logic [DATA_W-1:0] val_wdata;
   logic              lnk_we;
   logic [IDX_W-1:0]  lnk_waddr;
   logic [IDX_W-1:0]  lnk_wdata;
   logic [DATA_W-1:0] val_rd;
   logic [IDX_W-1:0]  lnk_rd;

   logic              req_fire;
   logic              out_free;
   logic              last_step;
   logic              is_full;
   logic              is_empty;

   llm_store #(
      .CAPACITY (CAPACITY)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .val_we    (val_we),
      .val_waddr (val_waddr),
      .val_wdata (val_wdata),
      .lnk_we    (lnk_we),
      .lnk_waddr (lnk_waddr),
      .lnk_wdata (lnk_wdata),
      .val_rd    (val_rd),
      .lnk_rd    (lnk_rd)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign last_step = (CNT_W'(step_ff + 1'b1) == count_ff);
   assign is_full   = (count_ff == CNT_W'(CAPACITY));
   assign is_empty  = (count_ff == '0);

   // sequencer next state and memory access
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      value_in      = value_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      free_in       = free_ff;
      count_in      = count_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      step_in       = step_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      rd_en         = 1'b0;
      rd_addr       = cur_ff;
      val_we        = 1'b0;
      val_waddr     = free_ff;
      val_wdata     = value_ff;
      lnk_we        = 1'b0;
      lnk_waddr     = free_ff;
      lnk_wdata     = head_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd_in   = cmd_type'(req_command);
               value_in = req_value;
               step_in  = '0;
               cur_in   = head_ff;
               unique case (cmd_type'(req_command))
                  CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
                     if (is_full) begin
                        pend_in  = ST_FULL;
                        state_in = S_RESP;
                     end else begin
                        // fetch the link of the node about to be taken
                        rd_en    = 1'b1;
                        rd_addr  = free_ff;
                        state_in = S_PUSH;
                     end
                  end
                  CMD_DELETE, CMD_DUMP: begin
                     if (is_empty) begin
                        pend_in  = ST_NONE;
                        state_in = S_RESP;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = head_ff;
                        state_in = (cmd_type'(req_command) == CMD_DELETE) ? S_SEARCH : S_DUMP;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         S_PUSH: begin
            // take the free head, store the value and splice it in
            free_in   = lnk_rd;
            val_we    = 1'b1;
            val_waddr = free_ff;
            val_wdata = value_ff;
            if (cmd_ff == CMD_PUSH_FRONT) begin
               lnk_we    = 1'b1;
               lnk_waddr = free_ff;
               lnk_wdata = head_ff;
               head_in   = free_ff;
               if (is_empty) begin
                  tail_in = free_ff;
               end
            end else begin
               if (is_empty) begin
                  head_in = free_ff;
               end else begin
                  lnk_we    = 1'b1;
                  lnk_waddr = tail_ff;
                  lnk_wdata = free_ff;
               end
               tail_in = free_ff;
            end
            count_in = CNT_W'(count_ff + 1'b1);
            pend_in  = ST_DONE;
            state_in = S_RESP;
         end

         S_SEARCH: begin
            // one node per cycle: compare, else follow the link
            if (val_rd == value_ff) begin
               if (step_ff == '0) begin
                  head_in = lnk_rd;
               end else begin
                  lnk_we    = 1'b1;
                  lnk_waddr = prev_ff;
                  lnk_wdata = lnk_rd;
               end
               if (last_step) begin
                  tail_in = prev_ff;
               end
               state_in = S_FREE;
            end else if (last_step) begin
               pend_in  = ST_NONE;
               state_in = S_RESP;
            end else begin
               prev_in = cur_ff;
               cur_in  = lnk_rd;
               step_in = CNT_W'(step_ff + 1'b1);
               rd_en   = 1'b1;
               rd_addr = lnk_rd;
            end
         end

         S_FREE: begin
            // return the unlinked node to the free list
            lnk_we    = 1'b1;
            lnk_waddr = cur_ff;
            lnk_wdata = free_ff;
            free_in   = cur_ff;
            count_in  = CNT_W'(count_ff - 1'b1);
            pend_in   = ST_DONE;
            state_in  = S_RESP;
         end

         S_DUMP: begin
            // one element word per cycle while the result register drains
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_ITEM;
               rsp_value_in  = val_rd;
               rsp_last_in   = last_step;
               if (last_step) begin
                  state_in = S_IDLE;
               end else begin
                  step_in = CNT_W'(step_ff + 1'b1);
                  rd_en   = 1'b1;
                  rd_addr = lnk_rd;
               end
            end
         end

         S_RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_ff;
               rsp_value_in  = '0;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state, list pointers and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         free_ff      <= '0;
         count_ff     <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         free_ff      <= free_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      value_ff      <= value_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      pend_ff       <= pend_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_item_value = rsp_value_ff;
   assign rsp_last       = rsp_last_ff;

   // element count stays within the store
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("element count above capacity");

   // a push on a full store leaves the count alone
   a_full_push_holds: assert property (@(posedge clock) disable iff (reset)
      (req_fire && is_full &&
       ((cmd_type'(req_command) == CMD_PUSH_FRONT) ||
        (cmd_type'(req_command) == CMD_PUSH_REAR)))
      |=> (count_ff == $past(count_ff)))
      else $error("full push changed the count");

   // a push that allocates adds exactly one element
   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PUSH) |=> (count_ff == CNT_W'($past(count_ff) + 1'b1)))
      else $error("push did not add one element");

endmodule

`default_nettype wire

@@ src/llm_store.sv @@
`default_nettype none

module llm_store import llm_pkg::*; #(
   parameter int unsigned CAPACITY = CAPACITY_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          rd_en,
   input  wire logic [$clog2(CAPACITY)-1:0]   rd_addr,
   input  wire logic                          val_we,
   input  wire logic [$clog2(CAPACITY)-1:0]   val_waddr,
   input  wire logic [DATA_W-1:0]             val_wdata,
   input  wire logic                          lnk_we,
   input  wire logic [$clog2(CAPACITY)-1:0]   lnk_waddr,
   input  wire logic [$clog2(CAPACITY)-1:0]   lnk_wdata,
   output logic      [DATA_W-1:0]             val_rd,
   output logic      [$clog2(CAPACITY)-1:0]   lnk_rd
);

   localparam int unsigned IDX_W = $clog2(CAPACITY);

   logic [DATA_W-1:0]   val_mem [CAPACITY];
   logic [IDX_W-1:0]    lnk_mem [CAPACITY];
   logic [CAPACITY-1:0] lnk_valid_ff;
   logic [DATA_W-1:0]   val_rd_ff;
   logic [IDX_W-1:0]    lnk_rd_ff;
   logic [IDX_W-1:0]    lnk_reset;

   // link of an entry never written: the free chain in index order
   assign lnk_reset = (rd_addr == IDX_W'(CAPACITY - 1)) ? '0 : IDX_W'(rd_addr + 1'b1);

   // written-entry marks for the link store
   always_ff @(posedge clock) begin
      if (reset) begin
         lnk_valid_ff <= '0;
      end else if (lnk_we) begin
         lnk_valid_ff[lnk_waddr] <= 1'b1;
      end
   end

   // value and link memories, registered read
   always_ff @(posedge clock) begin
      if (val_we) begin
         val_mem[val_waddr] <= val_wdata;
      end
      if (lnk_we) begin
         lnk_mem[lnk_waddr] <= lnk_wdata;
      end
      if (rd_en) begin
         val_rd_ff <= val_mem[rd_addr];
         lnk_rd_ff <= lnk_valid_ff[rd_addr] ? lnk_mem[rd_addr] : lnk_reset;
      end
   end

   assign val_rd = val_rd_ff;
   assign lnk_rd = lnk_rd_ff;

   // the sequencer never reads an entry whose link it writes in the same cycle
   a_no_rd_wr_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rd_en && lnk_we && (lnk_waddr == rd_addr)))
      else $error("link read and write hit the same entry");

   // a written link entry is marked valid afterwards
   a_valid_after_write: assert property (@(posedge clock) disable iff (reset)
      lnk_we |=> lnk_valid_ff[$past(lnk_waddr)])
      else $error("link entry not marked after write");

endmodule

`default_nettype wire
